// File: rtl/thdr_pkg.sv
// Shared constants, types and helper functions for the tile-hash dirty-region block.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package thdr_pkg;

  // Tile geometry and frame limits
  localparam int CELL_SIZE     = 8;
  localparam int CELL_LG       = $clog2(CELL_SIZE);
  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int TILE_COLS_MAX = (MAX_WIDTH + CELL_SIZE - 1) / CELL_SIZE;
  localparam int TILE_ROWS_MAX = (MAX_HEIGHT + CELL_SIZE - 1) / CELL_SIZE;
  localparam int TILES         = TILE_COLS_MAX * TILE_ROWS_MAX;

  // Widths
  localparam int DIM_W       = 10;                          // frame_width / frame_height
  localparam int COL_W       = $clog2(MAX_WIDTH);           // pixel column
  localparam int ROW_W       = $clog2(MAX_HEIGHT);          // pixel row
  localparam int TC_W        = $clog2(TILE_COLS_MAX);       // tile column
  localparam int TR_W        = $clog2(TILE_ROWS_MAX);       // tile row
  localparam int BOX_C_W     = $clog2(TILE_COLS_MAX + 1);   // box column, holds empty marker
  localparam int BOX_R_W     = $clog2(TILE_ROWS_MAX + 1);   // box row, holds empty marker
  localparam int IDX_W       = $clog2(TILES);               // tile store address
  localparam int HASH_W      = 32;
  localparam int PIX_W       = 16;
  localparam int RECT_POS_W  = 9;
  localparam int RECT_DIM_W  = 10;

  // Stream payload widths
  localparam int IN_FIELDS_W  = PIX_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 2 * RECT_POS_W + 2 * RECT_DIM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // FNV-1a
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd240;

  // Input item kinds
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // Per-pixel control carried down the pipeline
  typedef struct packed {
    logic [TC_W-1:0]  tc;
    logic [TR_W-1:0]  tr;
    logic [IDX_W-1:0] idx;
    logic             tile_start;
    logic             tile_end;
    logic             frame_end;
    logic             presented;
  } pix_ctl_t;

  // One tile-store write, kept for forwarding
  typedef struct packed {
    logic              wen;
    logic [IDX_W-1:0]  idx;
    logic [HASH_W-1:0] hash;
  } tile_wr_t;

  // Frame result
  typedef struct packed {
    logic [RECT_DIM_W-1:0] rect_height;
    logic [RECT_DIM_W-1:0] rect_width;
    logic [RECT_POS_W-1:0] rect_y;
    logic [RECT_POS_W-1:0] rect_x;
    logic                  changed;
  } result_t;

  // One FNV-1a step: xor the pixel in, multiply by the prime (constant, shift-add)
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [PIX_W-1:0]  p);
    logic [HASH_W-1:0] x;
    x = h ^ HASH_W'(p);
    return x * FNV_PRIME;
  endfunction

  // Zero becomes one, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > maxv) r = DIM_W'(maxv);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/thdr_col_hash.sv
// Running FNV-1a hash per tile column: column memory, hash step and forwarding.
// Depends on thdr_pkg.
`default_nettype none

module thdr_col_hash import thdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [TC_W-1:0]   rd_tc,
  input  logic              s1_valid,
  input  pix_ctl_t          s1_ctl,
  input  logic [PIX_W-1:0]  s1_pixel,
  output logic [HASH_W-1:0] s1_hash
);

  logic [HASH_W-1:0] col_mem [TILE_COLS_MAX];
  logic [HASH_W-1:0] rdata;
  logic [HASH_W-1:0] run_hash;
  logic [HASH_W-1:0] base;
  logic [TC_W-1:0]   last_tc;

  // read the column in S0, write back in S1
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= col_mem[rd_tc];
      if (s1_valid) col_mem[s1_ctl.tc] <= s1_hash;
    end
  end

  // the most recent hash always belongs to last_tc; memory may not have it yet
  always_ff @(posedge clk) begin
    if (adv && s1_valid) run_hash <= s1_hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tc <= '0;
    end else if (adv && s1_valid) begin
      last_tc <= s1_ctl.tc;
    end
  end

  always_comb begin
    if (s1_ctl.tile_start) base = FNV_BASIS;
    else if (last_tc == s1_ctl.tc) base = run_hash;
    else base = rdata;
  end

  assign s1_hash = fnv_step(base, s1_pixel);

endmodule

`default_nettype wire

// File: rtl/thdr_tile_cmp.sv
// Stored tile hashes: tile memory, compare against the new hash, write-back forwarding.
// Depends on thdr_pkg.
`default_nettype none

module thdr_tile_cmp import thdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic              s2_valid,
  input  pix_ctl_t          s2_ctl,
  input  logic [HASH_W-1:0] s2_hash,
  output logic              s2_changed
);

  logic [HASH_W-1:0] tile_mem [TILES];
  logic [HASH_W-1:0] rdata1;
  logic [HASH_W-1:0] rdata2;
  logic [HASH_W-1:0] stored;
  tile_wr_t          wr;
  tile_wr_t          hist1;
  tile_wr_t          hist2;

  assign wr.wen  = s2_valid && s2_ctl.tile_end;
  assign wr.idx  = s2_ctl.idx;
  assign wr.hash = s2_hash;

  // read in S0, carry through S1, compare and write in S2
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata1 <= tile_mem[rd_idx];
      rdata2 <= rdata1;
      if (wr.wen) tile_mem[wr.idx] <= wr.hash;
    end
  end

  // the two writes the S0 read could not see
  always_ff @(posedge clk) begin
    if (rst) begin
      hist1 <= '0;
      hist2 <= '0;
    end else if (adv) begin
      hist1 <= wr;
      hist2 <= hist1;
    end
  end

  always_comb begin
    if (hist1.wen && hist1.idx == s2_ctl.idx) stored = hist1.hash;
    else if (hist2.wen && hist2.idx == s2_ctl.idx) stored = hist2.hash;
    else stored = rdata2;
  end

  assign s2_changed = wr.wen && (!s2_ctl.presented || stored != s2_hash);

endmodule

`default_nettype wire

// File: rtl/thdr_box.sv
// Changed-tile bounding box and the frame result register.
// Depends on thdr_pkg.
`default_nettype none

module thdr_box import thdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             clear,
  input  logic [DIM_W-1:0] fw,
  input  logic [DIM_W-1:0] fh,
  input  logic             s3_valid,
  input  logic             s3_changed,
  input  pix_ctl_t         s3_ctl,
  input  logic             res_ready,
  output logic             res_valid,
  output result_t          res,
  output logic             stall
);

  logic [BOX_C_W-1:0]      min_c, min_c_next;
  logic [BOX_R_W-1:0]      min_r, min_r_next;
  logic [TC_W-1:0]         max_c, max_c_next;
  logic [TR_W-1:0]         max_r, max_r_next;
  logic                    any, any_next;
  logic                    upd;
  logic [BOX_C_W-1:0]      span_c;
  logic [BOX_R_W-1:0]      span_r;
  logic [RECT_POS_W-1:0]   rx, ry;
  logic [RECT_DIM_W-1:0]   rw_full, rh_full;
  logic [RECT_DIM_W:0]     sum_x, sum_y;
  result_t                 res_d;

  assign upd = s3_valid && s3_changed;

  always_comb begin
    min_c_next = (upd && BOX_C_W'(s3_ctl.tc) < min_c) ? BOX_C_W'(s3_ctl.tc) : min_c;
    min_r_next = (upd && BOX_R_W'(s3_ctl.tr) < min_r) ? BOX_R_W'(s3_ctl.tr) : min_r;
    max_c_next = (upd && s3_ctl.tc > max_c) ? s3_ctl.tc : max_c;
    max_r_next = (upd && s3_ctl.tr > max_r) ? s3_ctl.tr : max_r;
    any_next   = any || upd;
  end

  // tile box to pixel rectangle, clipped to the frame
  always_comb begin
    span_c  = BOX_C_W'(max_c_next) - min_c_next + BOX_C_W'(1);
    span_r  = BOX_R_W'(max_r_next) - min_r_next + BOX_R_W'(1);
    rx      = RECT_POS_W'(min_c_next) << CELL_LG;
    ry      = RECT_POS_W'(min_r_next) << CELL_LG;
    rw_full = RECT_DIM_W'(span_c) << CELL_LG;
    rh_full = RECT_DIM_W'(span_r) << CELL_LG;
    sum_x   = (RECT_DIM_W+1)'(rx) + (RECT_DIM_W+1)'(rw_full);
    sum_y   = (RECT_DIM_W+1)'(ry) + (RECT_DIM_W+1)'(rh_full);
    res_d   = '0;
    if (any_next) begin
      res_d.changed     = 1'b1;
      res_d.rect_x      = rx;
      res_d.rect_y      = ry;
      res_d.rect_width  = (sum_x > (RECT_DIM_W+1)'(fw)) ? fw - RECT_DIM_W'(rx) : rw_full;
      res_d.rect_height = (sum_y > (RECT_DIM_W+1)'(fh)) ? fh - RECT_DIM_W'(ry) : rh_full;
    end
  end

  // hold the pipeline only when a frame result would overwrite one still waiting
  assign stall = s3_valid && s3_ctl.frame_end && res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_c     <= BOX_C_W'(TILE_COLS_MAX);
      min_r     <= BOX_R_W'(TILE_ROWS_MAX);
      max_c     <= '0;
      max_r     <= '0;
      any       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (clear) begin
        min_c <= BOX_C_W'(TILE_COLS_MAX);
        min_r <= BOX_R_W'(TILE_ROWS_MAX);
        max_c <= '0;
        max_r <= '0;
        any   <= 1'b0;
      end else if (adv && s3_valid) begin
        if (s3_ctl.frame_end) begin
          res_valid <= 1'b1;
          min_c     <= BOX_C_W'(TILE_COLS_MAX);
          min_r     <= BOX_R_W'(TILE_ROWS_MAX);
          max_c     <= '0;
          max_r     <= '0;
          any       <= 1'b0;
        end else begin
          min_c <= min_c_next;
          min_r <= min_r_next;
          max_c <= max_c_next;
          max_r <= max_r_next;
          any   <= any_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid && s3_ctl.frame_end) res <= res_d;
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_ctl.frame_end) |=> res_valid)
    else $error("frame end did not load a result");

  a_box_restarts: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_ctl.frame_end) |=> !any)
    else $error("box not emptied after frame end");

  a_rect_in_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((RECT_DIM_W+1)'(res.rect_x) + (RECT_DIM_W+1)'(res.rect_width)
                   <= (RECT_DIM_W+1)'(fw)))
    else $error("result rectangle exceeds frame width");

endmodule

`default_nettype wire

// File: rtl/tile_hash_dirty_region.sv
// Top level of the tile-hash dirty-region detector: handshake, raster position,
// configuration and pipeline registers. Depends on thdr_pkg, thdr_col_hash,
// thdr_tile_cmp and thdr_box.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: pixel, present_ok; s_tuser: mode
// m_*       out  m_tvalid/m_tready  m_tdata: changed, rect_x, rect_y, rect_width, rect_height
// cfg_*     in   cfg_we             cfg_addr: register index; cfg_data: value
//
// One item per clock while s_tready is high. A pixel runs through four steps: S0 reads the
// column-hash and tile-hash memories, S1 applies the FNV-1a step, S2 compares with
// and writes the stored tile hash, S3 widens the box; the frame result is registered
// as its last pixel leaves S3. The per-column hash recurrence closes within S1
// through a forwarding register.
// Reset clears position, box, presented flag and config; the hash memories are not
// cleared. s_tready drops only while a result waits on m_tready and the next frame's
// last pixel has reached S3.

module tile_hash_dirty_region import thdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] pixel, [16] present_ok, rest zero
  input  logic                  s_tuser,   // [0] mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] changed, [9:1] rect_x, [18:10] rect_y,
                                           // [28:19] rect_width, [38:29] rect_height
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data
);

  logic [DIM_W-1:0]   fw, fh;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               presented;

  logic               adv, stall;
  logic               accept, pix_acc, rep_acc, cfg_hit;
  logic [PIX_W-1:0]   in_pixel;
  logic               in_present_ok;

  logic               last_col, last_row;
  logic               cell_col_end, cell_row_end;
  logic [BOX_C_W-1:0] tile_cols;
  pix_ctl_t           s0_ctl;

  logic               s1_valid, s2_valid, s3_valid;
  pix_ctl_t           s1_ctl, s2_ctl, s3_ctl;
  logic [PIX_W-1:0]   s1_pixel;
  logic [HASH_W-1:0]  s1_hash, s2_hash;
  logic               s2_changed, s3_changed;
  result_t            res;

  assign adv      = !stall;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;
  assign pix_acc  = accept && (s_tuser == MODE_PIXEL);
  assign rep_acc  = accept && (s_tuser == MODE_REPORT);
  assign cfg_hit  = cfg_we && (cfg_addr == CFG_FRAME_WIDTH || cfg_addr == CFG_FRAME_HEIGHT);

  assign in_pixel      = s_tdata[PIX_W-1:0];
  assign in_present_ok = s_tdata[PIX_W];

  // S0: raster position to tile coordinates and memory addresses
  always_comb begin
    last_col     = (DIM_W'(col) + DIM_W'(1)) >= fw;
    last_row     = (DIM_W'(row) + DIM_W'(1)) >= fh;
    cell_col_end = col[CELL_LG-1:0] == CELL_LG'(CELL_SIZE - 1);
    cell_row_end = row[CELL_LG-1:0] == CELL_LG'(CELL_SIZE - 1);
    tile_cols    = BOX_C_W'((fw + DIM_W'(CELL_SIZE - 1)) >> CELL_LG);

    s0_ctl.tc         = TC_W'(col >> CELL_LG);
    s0_ctl.tr         = TR_W'(row >> CELL_LG);
    s0_ctl.idx        = IDX_W'(s0_ctl.tr) * IDX_W'(tile_cols) + IDX_W'(s0_ctl.tc);
    s0_ctl.tile_start = (col[CELL_LG-1:0] == '0) && (row[CELL_LG-1:0] == '0);
    s0_ctl.tile_end   = (cell_col_end || last_col) && (cell_row_end || last_row);
    s0_ctl.frame_end  = last_col && last_row;
    s0_ctl.presented  = presented;
  end

  // configuration; a write to a frame-size register abandons the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= WIDTH_RESET;
      fh <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  fw <= clamp_dim(cfg_data, MAX_WIDTH);
        CFG_FRAME_HEIGHT: fh <= clamp_dim(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // advance the raster position on every accepted pixel
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (pix_acc) begin
      if (!last_col) begin
        col <= col + COL_W'(1);
      end else begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end
    end
  end

  // outcome report: takes effect for pixels accepted after it
  always_ff @(posedge clk) begin
    if (rst) begin
      presented <= 1'b0;
    end else if (rep_acc) begin
      presented <= in_present_ok;
    end
  end

  // pipeline valid bits; reports do not enter the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s3_changed <= 1'b0;
    end else if (adv) begin
      s1_valid   <= pix_acc;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      s3_changed <= s2_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl   <= s0_ctl;
      s1_pixel <= in_pixel;
      s2_ctl   <= s1_ctl;
      s2_hash  <= s1_hash;
      s3_ctl   <= s2_ctl;
    end
  end

  thdr_col_hash u_col_hash (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .rd_tc    (s0_ctl.tc),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_pixel (s1_pixel),
    .s1_hash  (s1_hash)
  );

  thdr_tile_cmp u_tile_cmp (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .rd_idx     (s0_ctl.idx),
    .s2_valid   (s2_valid),
    .s2_ctl     (s2_ctl),
    .s2_hash    (s2_hash),
    .s2_changed (s2_changed)
  );

  thdr_box u_box (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .clear      (cfg_hit),
    .fw         (fw),
    .fh         (fh),
    .s3_valid   (s3_valid),
    .s3_changed (s3_changed),
    .s3_ctl     (s3_ctl),
    .res_ready  (m_tready),
    .res_valid  (m_tvalid),
    .res        (res),
    .stall      (stall)
  );

  assign m_tdata = OUT_DATA_W'({res.rect_height, res.rect_width, res.rect_y,
                                res.rect_x, res.changed});

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input held without a waiting result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s3_valid && s3_ctl.frame_end))
    else $error("result appeared without a frame end");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col) < fw)
    else $error("raster column beyond frame width");

endmodule

`default_nettype wire

// File: dv/tile_hash_dirty_region_checker.sv
// Scoreboard for the tile-hash dirty-region block: watches the item, result and
// register channels, keeps its own copy of the tile hashes and the dirty box and
// compares every frame result. Depends on thdr_pkg.

module tile_hash_dirty_region_checker import thdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] pixel, [16] present_ok, rest zero
  input  logic                  s_tuser,   // [0] mode
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [0] changed, [9:1] rect_x, [18:10] rect_y,
                                           // [28:19] rect_width, [38:29] rect_height
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    frames_checked
);

  localparam logic [31:0] HASH_SEED = 32'h811C_9DC5;
  localparam logic [31:0] HASH_MULT = 32'h0100_0193;

  int unsigned act_w, act_h;
  logic [31:0] tile_sig [TILES];
  logic [31:0] col_sig [TILE_COLS_MAX];
  int unsigned px, py;
  int unsigned box_c0, box_r0, box_c1, box_r1;
  bit          dirty, shown;
  result_t     due_rects [$];
  result_t     want_rect, got_rect;
  int          fail_count = 0;
  int          seen_count = 0;

  function automatic int unsigned fit(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function void restart_frame();
    px = 0;
    py = 0;
    box_c0 = TILE_COLS_MAX;
    box_r0 = TILE_ROWS_MAX;
    box_c1 = 0;
    box_r1 = 0;
    dirty = 1'b0;
  endfunction

  // Build the frame result from the dirty box, clipped to the frame
  function void push_rect();
    result_t     r;
    int unsigned x0, y0, wd, ht;
    r = '0;
    r.changed = dirty;
    if (dirty) begin
      x0 = box_c0 * CELL_SIZE;
      y0 = box_r0 * CELL_SIZE;
      wd = (box_c1 - box_c0 + 1) * CELL_SIZE;
      ht = (box_r1 - box_r0 + 1) * CELL_SIZE;
      if (x0 + wd > act_w) wd = act_w - x0;
      if (y0 + ht > act_h) ht = act_h - y0;
      r.rect_x      = RECT_POS_W'(x0);
      r.rect_y      = RECT_POS_W'(y0);
      r.rect_width  = RECT_DIM_W'(wd);
      r.rect_height = RECT_DIM_W'(ht);
    end
    due_rects.push_back(r);
  endfunction

  // One FNV-1a step on the column's running hash; close the tile on its last pixel
  function void take_pixel(input logic [PIX_W-1:0] pix);
    int unsigned tc, tr, cols, slot;
    bit          end_c, end_r;
    logic [31:0] h;
    tc = px / CELL_SIZE;
    tr = py / CELL_SIZE;
    cols = (act_w + CELL_SIZE - 1) / CELL_SIZE;
    end_c = (px + 1 >= act_w);
    end_r = (py + 1 >= act_h);
    if (px % CELL_SIZE == 0 && py % CELL_SIZE == 0) h = HASH_SEED;
    else h = col_sig[tc];
    h = (h ^ 32'(pix)) * HASH_MULT;
    col_sig[tc] = h;
    if ((px % CELL_SIZE == CELL_SIZE - 1 || end_c) &&
        (py % CELL_SIZE == CELL_SIZE - 1 || end_r)) begin
      slot = tr * cols + tc;
      if (!shown || tile_sig[slot] != h) begin
        if (tc < box_c0) box_c0 = tc;
        if (tr < box_r0) box_r0 = tr;
        if (tc > box_c1) box_c1 = tc;
        if (tr > box_r1) box_r1 = tr;
        dirty = 1'b1;
      end
      tile_sig[slot] = h;
    end
    if (!end_c) begin
      px++;
    end else begin
      px = 0;
      if (!end_r) begin
        py++;
      end else begin
        push_rect();
        restart_frame();
      end
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      act_w = WIDTH_RESET;
      act_h = HEIGHT_RESET;
      shown = 1'b0;
      restart_frame();
      due_rects.delete();
    end else begin
      // any write to a real register drops the frame in progress
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_WIDTH: begin
            act_w = fit(cfg_data, MAX_WIDTH);
            restart_frame();
          end
          CFG_FRAME_HEIGHT: begin
            act_h = fit(cfg_data, MAX_HEIGHT);
            restart_frame();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_REPORT) shown = s_tdata[PIX_W];
        else take_pixel(s_tdata[PIX_W-1:0]);
      end
      if (m_tvalid && m_tready) begin
        got_rect = result_t'(m_tdata[OUT_FIELDS_W-1:0]);
        if (due_rects.size() == 0) begin
          $error("frame result with no frame pending: %h", m_tdata);
          fail_count++;
        end else begin
          want_rect = due_rects.pop_front();
          check_field("changed", want_rect.changed, got_rect.changed);
          check_field("rect_x", want_rect.rect_x, got_rect.rect_x);
          check_field("rect_y", want_rect.rect_y, got_rect.rect_y);
          check_field("rect_width", want_rect.rect_width, got_rect.rect_width);
          check_field("rect_height", want_rect.rect_height, got_rect.rect_height);
        end
        seen_count++;
      end
    end
    mismatches     <= fail_count;
    pending        <= due_rects.size();
    frames_checked <= seen_count;
  end

endmodule

// File: dv/tile_hash_dirty_region_test.sv
// Top of the tile-hash dirty-region testbench: clock, reset, pixel and report
// stimulus, register writes, result back-pressure and the verdict.
// Depends on thdr_pkg, tile_hash_dirty_region and tile_hash_dirty_region_checker.

module tile_hash_dirty_region_test;
  import thdr_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int RANDOM_ITEMS  = 100;
  localparam int RANDOM_FRAMES = 8;
  localparam int DRAIN_CYCLES  = 8;     // pipeline is four steps deep

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] SPARE_INDEX_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] SPARE_INDEX_HI = 2'd3;

  typedef enum int {
    KIND_STILL,    // the scene as it stands
    KIND_PATCH,    // scene with a small rectangle scrambled
    KIND_NOISE,    // every pixel random
    KIND_CHECKER   // alternating all-zero and all-one pixels
  } frame_kind_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [15:0] pixel, [16] present_ok, rest zero
  logic                  s_tuser;   // [0] mode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [0] changed, [9:1] rect_x, [18:10] rect_y,
                                    // [28:19] rect_width, [38:29] rect_height
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DIM_W-1:0]      cfg_data;

  int mismatches, pending, frames_checked;

  // stimulus-side bookkeeping
  bit          calm;               // no idling on either side
  int unsigned fw, fh;             // frame size the block is running with
  bit          tile_done [TILES];  // stored hash written at this index
  frame_kind_t frame_kind;
  logic [31:0] scene;
  int unsigned ex0, ey0, ex1, ey1;
  int          items_sent, reports_sent, frames_sent, aborts;
  int          quiet;
  int          m_hold;

  tile_hash_dirty_region dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  tile_hash_dirty_region_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: hold m_tready low in random bursts
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      m_hold <= 0;
    end else if (m_hold > 0) begin
      m_tready <= 1'b0;
      m_hold <= m_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      m_hold <= int'($urandom_range(0, 18));
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: a correct run never goes this long without some handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned fit(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Check (and with mark set, record) that every tile of the current size has a
  // stored hash; a report of success is only safe when this holds.
  function automatic bit tiles_cover(input bit mark);
    int unsigned cols, rows;
    bit          all_set;
    cols = (fw + CELL_SIZE - 1) / CELL_SIZE;
    rows = (fh + CELL_SIZE - 1) / CELL_SIZE;
    all_set = 1'b1;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        if (!tile_done[r * cols + c]) all_set = 1'b0;
        if (mark) tile_done[r * cols + c] = 1'b1;
      end
    end
    return all_set;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_value(input int unsigned x, input int unsigned y);
    logic [31:0] mix;
    mix = (x * 32'h9E37_79B1) ^ (y * 32'h85EB_CA77) ^ scene;
    mix = mix ^ (mix >> 15);
    case (frame_kind)
      KIND_NOISE:   return PIX_W'($urandom);
      KIND_CHECKER: return ((x ^ y) & 1) ? 16'hFFFF : 16'h0000;
      KIND_PATCH:
        if (x >= ex0 && x <= ex1 && y >= ey0 && y <= ey1)
          return mix[PIX_W-1:0] ^ PIX_W'($urandom_range(1, 65535));
      default: ;
    endcase
    return mix[PIX_W-1:0];
  endfunction

  // Present one item; idle first now and then. s_tvalid is only lowered at the
  // start of a gap, never in the step where the next item raises it.
  task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix, input logic flag);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 19) == 0) begin
      gap = int'($urandom_range(1, 19));
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_DATA_W'({flag, pix});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Report the display outcome; never claim success while some tile of this
  // size has no stored hash to compare against.
  task automatic send_report(input bit ok);
    if (ok && !tiles_cover(1'b0)) ok = 1'b0;
    send_item(MODE_REPORT, PIX_W'($urandom), ok);
    reports_sent++;
  endtask

  task automatic plan_frame(input frame_kind_t kind);
    frame_kind = kind;
    ex0 = $urandom_range(0, fw - 1);
    ey0 = $urandom_range(0, fh - 1);
    ex1 = ex0 + $urandom_range(0, 11);
    ey1 = ey0 + $urandom_range(0, 11);
  endtask

  // Raster pixels [first, stop) of the planned frame, with a rare report inside
  task automatic send_pixels(input int unsigned first, input int unsigned stop);
    for (int unsigned p = first; p < stop; p++) begin
      if ($urandom_range(0, 399) == 0) send_report(1'($urandom_range(0, 1)));
      send_item(MODE_PIXEL, pixel_value(p % fw, p / fw), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_frame(input frame_kind_t kind);
    plan_frame(kind);
    send_pixels(0, fw * fh);
    void'(tiles_cover(1'b1));
    frames_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] index, input logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // New frame size, written while the block is idle. A size whose tiles were
  // never all hashed starts with the presented flag cleared.
  task automatic set_geometry(input logic [DIM_W-1:0] wv, input logic [DIM_W-1:0] hv);
    settle();
    cfg_write(CFG_FRAME_WIDTH, wv);
    cfg_write(CFG_FRAME_HEIGHT, hv);
    fw = fit(wv, MAX_WIDTH);
    fh = fit(hv, MAX_HEIGHT);
    if (!tiles_cover(1'b0)) send_report(1'b0);
  endtask

  initial begin
    logic [DIM_W-1:0] wv, hv;
    int               runs, base_items, base_frames;
    frame_kind_t      kind;

    s_tvalid = 1'b0;
    s_tuser  = MODE_PIXEL;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = CFG_FRAME_WIDTH;
    cfg_data = '0;
    calm     = 1'b0;
    rst      = 1'b1;
    fw       = WIDTH_RESET;
    fh       = HEIGHT_RESET;
    scene    = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // Start a frame at the reset size; the first size change drops it
    plan_frame(KIND_STILL);
    send_pixels(0, 16);
    aborts++;

    // Register value zero reads as one: a single-pixel frame
    set_geometry(10'd0, 10'd0);
    send_frame(KIND_STILL);
    send_report(1'b1);
    send_frame(KIND_STILL);     // same pixel, presented: nothing changed
    send_frame(KIND_CHECKER);   // all-zero pixel
    send_frame(KIND_PATCH);

    // Two pixels: all-zero next to all-one
    set_geometry(10'd2, 10'd1);
    send_frame(KIND_CHECKER);
    send_report(1'b1);
    send_frame(KIND_CHECKER);

    // Edge tiles clipped on the right and at the bottom
    set_geometry(10'd9, 10'd9);
    send_frame(KIND_STILL);
    send_report(1'b1);
    send_frame(KIND_STILL);
    send_report(1'b0);          // failed display: everything counts as changed

    // Writes past the register list in the middle of a frame leave it running
    plan_frame(KIND_STILL);
    send_pixels(0, 30);
    settle();
    cfg_write(SPARE_INDEX_LO, DIM_W'($urandom));
    cfg_write(SPARE_INDEX_HI, DIM_W'($urandom));
    send_pixels(30, fw * fh);
    void'(tiles_cover(1'b1));
    frames_sent++;

    // A real write abandons the frame; sizes above the maximum saturate
    plan_frame(KIND_NOISE);
    send_pixels(0, 20);
    aborts++;
    set_geometry(10'd1023, 10'd1);
    send_frame(KIND_NOISE);
    set_geometry(10'd1, 10'd600);
    send_frame(KIND_CHECKER);

    // --- random part: small frames of random size and content ---
    base_items  = items_sent;
    base_frames = frames_checked;
    while (items_sent - base_items < RANDOM_ITEMS ||
           frames_checked - base_frames < RANDOM_FRAMES) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          wv = '0;
          hv = DIM_W'($urandom_range(0, 12));
        end
        1, 2, 3: begin           // tiny frames: results back to back
          wv = DIM_W'($urandom_range(1, 3));
          hv = DIM_W'($urandom_range(1, 3));
        end
        default: begin
          wv = DIM_W'($urandom_range(1, 16));
          hv = DIM_W'($urandom_range(1, 10));
        end
      endcase
      if ($urandom_range(0, 2) == 0) scene = $urandom;
      set_geometry(wv, hv);
      runs = int'($urandom_range(2, 4));
      repeat (runs) begin
        if ($urandom_range(0, 2) == 0) send_report($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2:    kind = KIND_STILL;
          3, 4, 5, 6: kind = KIND_PATCH;
          7, 8:       kind = KIND_NOISE;
          default:    kind = KIND_CHECKER;
        endcase
        send_frame(kind);
      end
      // now and then leave a frame unfinished for the next size change to drop
      if ($urandom_range(0, 9) == 0) begin
        plan_frame(KIND_NOISE);
        send_pixels(0, $urandom_range(0, fw * fh - 1));
        aborts++;
      end
    end

    // --- last part: no idling, single-pixel frames back to back ---
    calm = 1'b1;
    set_geometry(10'd1, 10'd1);
    repeat (6) send_frame(KIND_NOISE);
    settle();

    $display("Sent %0d items (%0d outcome reports) in %0d full and %0d dropped frames.",
             items_sent, reports_sent, frames_sent, aborts);
    $display("Compared %0d frame results, sizes from 1x1 up to full width and height.",
             frames_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
